@@ rtl/trp_pkg.sv @@
// Package for the tilt roll/pitch unit: widths, pipeline depth, sideband type
// and the arctangent table used by the CORDIC stages. No dependencies.
package trp_pkg;

  localparam int AXIS_WIDTH    = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_FRAC     = 7;

  localparam int ROOT_W  = AXIS_WIDTH + SQRT_FRAC;
  localparam int SQ_W    = 2 * AXIS_WIDTH - 1;
  localparam int SUM_W   = 2 * AXIS_WIDTH;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CD_W    = ROOT_W + 3;
  localparam int ACC_W   = 26;
  localparam int RND_W   = ACC_W - 8;
  localparam int ROLL_W  = 17;
  localparam int PITCH_W = 16;
  localparam int TAB_IDX_W = 5;

  localparam int DEG180_ACC = 11796480;
  localparam int ROLL_MAX   = 46080;
  localparam int PITCH_MAX  = 23040;

  localparam int LAT = 5 + ROOT_W + CORDIC_STAGES;

  typedef struct packed {
    logic                         zero;
    logic                         zle;
    logic signed [AXIS_WIDTH-1:0] x;
    logic signed [AXIS_WIDTH-1:0] y;
  } side_t;

  function automatic logic signed [ACC_W-1:0] atan_deg16(input logic [TAB_IDX_W-1:0] i);
    logic signed [ACC_W-1:0] r;
    unique case (i)
      5'd0:    r = ACC_W'(2949120);
      5'd1:    r = ACC_W'(1740967);
      5'd2:    r = ACC_W'(919879);
      5'd3:    r = ACC_W'(466945);
      5'd4:    r = ACC_W'(234379);
      5'd5:    r = ACC_W'(117305);
      5'd6:    r = ACC_W'(58666);
      5'd7:    r = ACC_W'(29335);
      5'd8:    r = ACC_W'(14668);
      5'd9:    r = ACC_W'(7334);
      5'd10:   r = ACC_W'(3667);
      5'd11:   r = ACC_W'(1833);
      5'd12:   r = ACC_W'(917);
      5'd13:   r = ACC_W'(458);
      5'd14:   r = ACC_W'(229);
      5'd15:   r = ACC_W'(115);
      5'd16:   r = ACC_W'(57);
      5'd17:   r = ACC_W'(29);
      5'd18:   r = ACC_W'(14);
      5'd19:   r = ACC_W'(7);
      5'd20:   r = ACC_W'(4);
      5'd21:   r = ACC_W'(2);
      5'd22:   r = ACC_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/trp_if.sv @@
// Valid/ready channel interfaces for samples and angle results.
// Depends on trp_pkg for field widths.
interface trp_smp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [trp_pkg::AXIS_WIDTH-1:0] x_value;
  logic signed [trp_pkg::AXIS_WIDTH-1:0] y_value;
  logic signed [trp_pkg::AXIS_WIDTH-1:0] z_value;
  modport source(output valid, x_value, y_value, z_value, input ready);
  modport sink(input valid, x_value, y_value, z_value, output ready);
endinterface

interface trp_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [trp_pkg::ROLL_W-1:0]  roll_deg;
  logic signed [trp_pkg::PITCH_W-1:0] pitch_deg;
  logic                               zero_vector;
  modport source(output valid, roll_deg, pitch_deg, zero_vector, input ready);
  modport sink(input valid, roll_deg, pitch_deg, zero_vector, output ready);
endinterface

@@ rtl/trp_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on trp_pkg.
module trp_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [trp_pkg::SUM_W-1:0]     rad_i,
  output logic [trp_pkg::ROOT_W-1:0]    root_o
);
  localparam int RW = trp_pkg::ROOT_W;
  localparam int NW = trp_pkg::RAD_W;
  localparam int MW = trp_pkg::REM_W;

  logic [MW-1:0] rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [NW-1:0] n_q    [RW+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign n_q[0]    = {rad_i, {(2*trp_pkg::SQRT_FRAC){1'b0}}};

  for (genvar j = 0; j < RW; j++) begin : g_stg
    logic [MW-1:0] cur, trial;
    assign cur   = {rem_q[j][MW-3:0], n_q[j][NW-1:NW-2]};
    assign trial = {root_q[j], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1] <= {n_q[j][NW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[j+1]  <= cur - trial;
          root_q[j+1] <= {root_q[j][RW-2:0], 1'b1};
        end else begin
          rem_q[j+1]  <= cur;
          root_q[j+1] <= {root_q[j][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RW];
endmodule

@@ rtl/trp_cordic.sv @@
// Pipelined CORDIC vectoring atan2(b, a) in degrees, 16 fraction bits.
// One pre-rotation stage then one stage per iteration. Depends on trp_pkg.
module trp_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [trp_pkg::CD_W-1:0]    b_i,
  input  logic signed [trp_pkg::CD_W-1:0]    a_i,
  output logic signed [trp_pkg::ACC_W-1:0]   acc_o
);
  localparam int N = trp_pkg::CORDIC_STAGES;

  logic signed [trp_pkg::CD_W-1:0]  a_q   [N+1];
  logic signed [trp_pkg::CD_W-1:0]  b_q   [N+1];
  logic signed [trp_pkg::ACC_W-1:0] acc_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (a_i < 0) begin
        a_q[0]   <= -a_i;
        b_q[0]   <= -b_i;
        acc_q[0] <= (b_i < 0) ? -trp_pkg::ACC_W'(trp_pkg::DEG180_ACC)
                              : trp_pkg::ACC_W'(trp_pkg::DEG180_ACC);
      end else begin
        a_q[0]   <= a_i;
        b_q[0]   <= b_i;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stg
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!b_q[k][trp_pkg::CD_W-1]) begin
          a_q[k+1]   <= a_q[k] + (b_q[k] >>> k);
          b_q[k+1]   <= b_q[k] - (a_q[k] >>> k);
          acc_q[k+1] <= acc_q[k] + trp_pkg::atan_deg16(trp_pkg::TAB_IDX_W'(k));
        end else begin
          a_q[k+1]   <= a_q[k] - (b_q[k] >>> k);
          b_q[k+1]   <= b_q[k] + (a_q[k] >>> k);
          acc_q[k+1] <= acc_q[k] - trp_pkg::atan_deg16(trp_pkg::TAB_IDX_W'(k));
        end
      end
    end
  end

  assign acc_o = acc_q[N];
endmodule

@@ rtl/tilt_roll_pitch_from_three_axes_unit.sv @@
// Top level of the tilt unit: roll and pitch from one three-axis sample.
// Depends on trp_pkg, trp_if, trp_sqrt and trp_cordic.
//
// smp_i carries one signed x/y/z sample per beat; res_o returns one beat with
// roll_deg, pitch_deg (degrees, 8 fraction bits) and zero_vector.
// The pipeline is built from the input register, squares, sums, one
// square-root stage per root bit (21), the CORDIC pre-rotation stage and one stage per
// iteration (16), and the output register. Throughput is one beat per cycle
// unless the receiver stalls; every stage is a register with valid bit.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled receiver freezes every stage and smp_i.ready
// drops; nothing is lost or repeated. Reset clears the valid bits only.
// An all-zero sample gives zero angles with zero_vector set.
module tilt_roll_pitch_from_three_axes_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  trp_smp_if.sink       smp_i,
  trp_res_if.source     res_o
);
  localparam int AW = trp_pkg::AXIS_WIDTH;
  localparam int RW = trp_pkg::ROOT_W;
  localparam int N  = trp_pkg::CORDIC_STAGES;
  localparam int L  = trp_pkg::LAT;
  localparam int CW = trp_pkg::CD_W;

  logic en;
  logic vld_q [L];

  assign en          = !vld_q[L-1] || res_o.ready;
  assign smp_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < L; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= smp_i.valid;
      for (int k = 1; k < L; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  logic signed [AW-1:0] x0_q, y0_q, z0_q;
  logic [trp_pkg::SQ_W-1:0]  sqx_q, sqy_q, sqz_q;
  logic [trp_pkg::SUM_W-1:0] sxz_q, syz_q;
  logic signed [2*AW-1:0] px, py, pz;
  trp_pkg::side_t side1_q, side2_q;
  trp_pkg::side_t sd_q [RW];

  assign px = x0_q * x0_q;
  assign py = y0_q * y0_q;
  assign pz = z0_q * z0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= smp_i.x_value;
      y0_q <= smp_i.y_value;
      z0_q <= smp_i.z_value;
      sqx_q <= px[trp_pkg::SQ_W-1:0];
      sqy_q <= py[trp_pkg::SQ_W-1:0];
      sqz_q <= pz[trp_pkg::SQ_W-1:0];
      side1_q.zero <= (x0_q == '0) && (y0_q == '0) && (z0_q == '0);
      side1_q.zle  <= z0_q[AW-1] || (z0_q == '0);
      side1_q.x    <= x0_q;
      side1_q.y    <= y0_q;
      sxz_q   <= trp_pkg::SUM_W'(sqx_q) + trp_pkg::SUM_W'(sqz_q);
      syz_q   <= trp_pkg::SUM_W'(sqy_q) + trp_pkg::SUM_W'(sqz_q);
      side2_q <= side1_q;
      sd_q[0] <= side2_q;
      for (int k = 1; k < RW; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  logic [RW-1:0] rxz, ryz;

  trp_sqrt u_sqrt_xz (.clk_i(clk_i), .en_i(en), .rad_i(sxz_q), .root_o(rxz));
  trp_sqrt u_sqrt_yz (.clk_i(clk_i), .en_i(en), .rad_i(syz_q), .root_o(ryz));

  trp_pkg::side_t sd;
  logic signed [CW-1:0] ra, rb, pa, pb;

  assign sd = sd_q[RW-1];
  assign ra = sd.zle ? -$signed({{(CW-RW){1'b0}}, rxz}) : $signed({{(CW-RW){1'b0}}, rxz});
  assign rb = {{(CW-AW-trp_pkg::SQRT_FRAC){sd.y[AW-1]}}, sd.y, {trp_pkg::SQRT_FRAC{1'b0}}};
  assign pa = $signed({{(CW-RW){1'b0}}, ryz});
  assign pb = {{(CW-AW-trp_pkg::SQRT_FRAC){sd.x[AW-1]}}, sd.x, {trp_pkg::SQRT_FRAC{1'b0}}};

  logic signed [trp_pkg::ACC_W-1:0] racc, pacc;

  trp_cordic u_cordic_roll  (.clk_i(clk_i), .en_i(en), .b_i(rb), .a_i(ra), .acc_o(racc));
  trp_cordic u_cordic_pitch (.clk_i(clk_i), .en_i(en), .b_i(pb), .a_i(pa), .acc_o(pacc));

  logic zd_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q[0] <= sd.zero;
      for (int k = 1; k <= N; k++) zd_q[k] <= zd_q[k-1];
    end
  end

  logic signed [trp_pkg::ACC_W-1:0] rsum, psum;
  logic signed [trp_pkg::RND_W-1:0] rrnd, prnd, rcl, pcl;

  assign rsum = racc + trp_pkg::ACC_W'(128);
  assign psum = pacc + trp_pkg::ACC_W'(128);
  assign rrnd = trp_pkg::RND_W'(rsum >>> 8);
  assign prnd = trp_pkg::RND_W'(psum >>> 8);

  always_comb begin
    rcl = rrnd;
    if (rrnd > trp_pkg::RND_W'(trp_pkg::ROLL_MAX))  rcl = trp_pkg::RND_W'(trp_pkg::ROLL_MAX);
    if (rrnd < -trp_pkg::RND_W'(trp_pkg::ROLL_MAX)) rcl = -trp_pkg::RND_W'(trp_pkg::ROLL_MAX);
    pcl = prnd;
    if (prnd > trp_pkg::RND_W'(trp_pkg::PITCH_MAX))  pcl = trp_pkg::RND_W'(trp_pkg::PITCH_MAX);
    if (prnd < -trp_pkg::RND_W'(trp_pkg::PITCH_MAX)) pcl = -trp_pkg::RND_W'(trp_pkg::PITCH_MAX);
  end

  logic signed [trp_pkg::ROLL_W-1:0]  roll_q;
  logic signed [trp_pkg::PITCH_W-1:0] pitch_q;
  logic                               zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q  <= zd_q[N];
      roll_q  <= zd_q[N] ? '0 : rcl[trp_pkg::ROLL_W-1:0];
      pitch_q <= zd_q[N] ? '0 : pcl[trp_pkg::PITCH_W-1:0];
    end
  end

  assign res_o.valid       = vld_q[L-1];
  assign res_o.roll_deg    = roll_q;
  assign res_o.pitch_deg   = pitch_q;
  assign res_o.zero_vector = zero_q;

  a_zero_angles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.zero_vector) |-> (res_o.roll_deg == '0 && res_o.pitch_deg == '0))
    else $error("zero sample with nonzero angle");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.pitch_deg <= 16'sd23040 && res_o.pitch_deg >= -16'sd23040))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.roll_deg <= 17'sd46080 && res_o.roll_deg >= -17'sd46080))
    else $error("roll out of range");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !smp_i.ready)
    else $error("input taken while output stalled");
endmodule

@@ tb/tilt_roll_pitch_from_three_axes_unit_chk.sv @@
// Checker for the tilt unit: watches sample and result channels, predicts roll,
// pitch and the zero flag per sample beat, and compares in order. Uses trp_pkg.
module tilt_roll_pitch_from_three_axes_unit_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  trp_smp_if          smp,
  trp_res_if          res,
  output int unsigned err_cnt_o,
  output int unsigned pend_o,
  output int unsigned res_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [trp_pkg::ROLL_W-1:0]  roll;
    logic signed [trp_pkg::PITCH_W-1:0] pitch;
    logic                               zero;
  } angles_t;

  angles_t angles_q[$];
  int unsigned errs = 0;
  int unsigned got = 0;

  localparam longint ATAN_TAB[24] = '{2949120, 1740967, 919879, 466945, 234379,
    117305, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0};

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint b, longint a);
    longint acc, da, db;
    acc = 0;
    if (a < 0) begin
      acc = (b < 0) ? -trp_pkg::DEG180_ACC : trp_pkg::DEG180_ACC;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < trp_pkg::CORDIC_STAGES && i < 24; i++) begin
      da = floor_shr(b, i);
      db = floor_shr(a, i);
      if (b >= 0) begin
        a += da; b -= db; acc += ATAN_TAB[i];
      end else begin
        a -= da; b += db; acc -= ATAN_TAB[i];
      end
    end
    return acc;
  endfunction

  function automatic longint round_clamp(longint acc, longint lim);
    longint v;
    v = floor_shr(acc + 128, 8);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic angles_t tilt_angles(longint x, longint y, longint z);
    angles_t r;
    longint rxz, ryz;
    r = '0;
    if (x == 0 && y == 0 && z == 0) begin
      r.zero = 1'b1;
    end else begin
      rxz = int_root((x * x + z * z) <<< (2 * trp_pkg::SQRT_FRAC));
      ryz = int_root((y * y + z * z) <<< (2 * trp_pkg::SQRT_FRAC));
      if (z <= 0) rxz = -rxz;
      r.roll  = trp_pkg::ROLL_W'(round_clamp(
        vector_angle(y <<< trp_pkg::SQRT_FRAC, rxz), trp_pkg::ROLL_MAX));
      r.pitch = trp_pkg::PITCH_W'(round_clamp(
        vector_angle(x <<< trp_pkg::SQRT_FRAC, ryz), trp_pkg::PITCH_MAX));
    end
    return r;
  endfunction

  task automatic report(string what, longint got_v, longint exp_v);
    errs++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got_v, exp_v);
  endtask

  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni && res.valid && res.ready) begin
      got++;
      if (angles_q.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        e = angles_q.pop_front();
        if (res.roll_deg !== e.roll) report("roll", res.roll_deg, e.roll);
        if (res.pitch_deg !== e.pitch) report("pitch", res.pitch_deg, e.pitch);
        if (res.zero_vector !== e.zero) report("zero_vector", res.zero_vector, e.zero);
      end
    end
    if (rst_ni && smp.valid && smp.ready)
      angles_q.push_back(tilt_angles(smp.x_value, smp.y_value, smp.z_value));
  end

  assign err_cnt_o = errs;
  assign pend_o    = angles_q.size();
  assign res_cnt_o = got;
endmodule

@@ tb/tilt_roll_pitch_from_three_axes_unit_tb.sv @@
// Testbench top for the tilt unit: drives directed and random samples with
// random idling and stalls, and gives the verdict. Uses the checker module.
module tilt_roll_pitch_from_three_axes_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned err_cnt, pend, res_cnt;
  bit quiet = 0;
  bit long_hold = 0;

  trp_smp_if smp ();
  trp_res_if res ();

  always #4 clk_i = ~clk_i;

  tilt_roll_pitch_from_three_axes_unit uut (.clk_i, .rst_ni, .smp_i(smp), .res_o(res));

  tilt_roll_pitch_from_three_axes_unit_chk chk (.clk_i, .rst_ni, .smp, .res,
    .err_cnt_o(err_cnt), .pend_o(pend), .res_cnt_o(res_cnt));

  localparam int AMAX = (1 << (trp_pkg::AXIS_WIDTH - 1)) - 1;
  localparam int AMIN = -(1 << (trp_pkg::AXIS_WIDTH - 1));

  initial begin
    smp.valid = 1'b0;
    smp.x_value = '0;
    smp.y_value = '0;
    smp.z_value = '0;
    res.ready = 1'b0;
  end

  task automatic send(int x, int y, int z);
    smp.valid   <= 1'b1;
    smp.x_value <= trp_pkg::AXIS_WIDTH'(x);
    smp.y_value <= trp_pkg::AXIS_WIDTH'(y);
    smp.z_value <= trp_pkg::AXIS_WIDTH'(z);
    do @(posedge clk_i); while (!smp.ready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic int rand_axis();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? AMAX : AMIN;
      1: return int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, AMAX - AMIN)) + AMIN;
    endcase
  endfunction

  // receiver: random stalls, one long hold, none when quiet
  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        res.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(0, 0, 0);
    send(AMAX, AMAX, AMAX);
    send(AMIN, AMIN, AMIN);
    send(AMIN, AMAX, AMIN);
    send(AMAX, AMIN, 0);
    send(5, 0, 0);
    send(-5, 0, -3);
    send(0, 7, 0);
    send(0, -7, 0);
    send(AMIN, 0, 0);
    send(0, 0, AMIN);
    send(0, 0, 1);
    send(1, -1, -1);
    send(-1, 1, 1);
    send(3, -4, AMAX);
    send(AMAX, 0, AMIN);
    // hold off the receiver while samples keep coming
    long_hold = 1;
    for (n = 0; n < 100; n++) send(rand_axis(), rand_axis(), rand_axis());
    smp.valid <= 1'b0;
    while (pend != 0) @(posedge clk_i);
    for (n = 0; n < 1100; n++) begin
      if (n == 900) quiet = 1;
      send(rand_axis(), rand_axis(), rand_axis());
    end
    smp.valid <= 1'b0;
    while (pend != 0) @(posedge clk_i);
    repeat (trp_pkg::LAT + 10) @(posedge clk_i);
    $display("covered %0d results: axis extremes, zero vector, half-plane cases, stalls",
             res_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
